### sv/ifus_pkg.sv
`timescale 1ns / 1ps

package ifus_pkg;

  // Burst geometry: 23 bytes per frame, only bytes 0 to 20 carry fields.
  localparam int FRAME_BYTES = 23;
  localparam int FIELD_BYTES = 21;
  localparam int POS_W       = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // Byte offsets inside the burst.
  localparam int ACCEL_BASE  = 0;
  localparam int GYRO_BASE   = 6;
  localparam int TEMP_BASE   = 12;
  localparam int STATUS_BYTE = 14;
  localparam int MAG_BASE    = 15;

  // Datapath widths: 16-bit count times 32-bit unsigned Q8.24 gain.
  localparam int COUNT_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int Q_W        = 32;
  localparam int PROD_W     = COUNT_W + GAIN_W + 1;
  localparam int FRAC_SHIFT = 8;
  localparam int SHR_W      = PROD_W - FRAC_SHIFT;

  localparam int LANES  = 10;
  localparam int OUT_W  = LANES * Q_W;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GYRO_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAG_GAIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_GAIN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_OFFSET = 3'd4;

  // Register reset values.
  localparam logic [GAIN_W-1:0]     ACCEL_GAIN_RST  = 32'd80365;
  localparam logic [GAIN_W-1:0]     GYRO_GAIN_RST   = 32'd17855;
  localparam logic [GAIN_W-1:0]     MAG_GAIN_RST    = 32'd2516582;
  localparam logic [GAIN_W-1:0]     TEMP_GAIN_RST   = 32'd50251;
  localparam logic signed [Q_W-1:0] TEMP_OFFSET_RST = 32'sd1376256;

  // Saturation limits of signed Q16.16, held at the width of the shifted product.
  localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'(64'sd2147483647);
  localparam logic signed [SHR_W-1:0] SAT_LO = SHR_W'(-64'sd2147483648);

  // Load strobes for the two register stages of every scaling lane.
  typedef struct packed {
    logic prod_load;
    logic out_load;
  } pipe_ctrl_t;

  // Clamp a wide signed value into signed Q16.16.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SHR_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/imu_frame_unpack_scale_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Word                                   Side band
// s_axis    in         tdata[7:0] data_byte                   tuser[0] frame_start
// m_axis    out        tdata 10 x 32 bit Q16.16, see port     tuser[0] mag_valid
// cfg       in         cfg_addr selects, cfg_wdata 32 bit     none
//
// One byte is taken per cycle while s_tready is high. After its 23rd byte a frame
// passes through the product registers and then the saturate and offset stage.
// Reset is synchronous; the byte count, pipeline valids and last magnetometer
// sample are cleared, the first-frame flag is set, and the gains and temperature
// offset return to their defaults. When the output stalls and the product stage is
// full, s_tready drops until the result register is taken.

module imu_frame_unpack_scale_top import ifus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tuser,   // [0] frame_start
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y,
                                           // gyro_z, mag_x, mag_y, mag_z, temperature,
                                           // 32 bits each from bit 0 up
  output logic                  m_tuser,   // [0] mag_valid
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [GAIN_W-1:0]     cfg_wdata
);

  logic [GAIN_W-1:0]     accel_gain;
  logic [GAIN_W-1:0]     gyro_gain;
  logic [GAIN_W-1:0]     mag_gain;
  logic [GAIN_W-1:0]     temp_gain;
  logic signed [Q_W-1:0] temp_offset;

  logic [POS_W-1:0]      byte_position;
  logic [POS_W-1:0]      pos_cur;
  logic [7:0]            frame_bytes [FIELD_BYTES];
  logic [COUNT_W-1:0]    previous_mag [3];
  logic                  first_frame;

  logic                  s1_valid;
  logic                  s1_mag_valid;
  logic                  s1_go;
  logic                  accept;
  logic                  final_acc;
  logic                  is_new;

  logic [COUNT_W-1:0]        mag_raw [3];
  logic signed [COUNT_W-1:0] counts  [LANES];
  logic [GAIN_W-1:0]         gains   [LANES];
  logic signed [Q_W-1:0]     offsets [LANES];
  logic signed [Q_W-1:0]     results [LANES];
  pipe_ctrl_t                ctrl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain  <= ACCEL_GAIN_RST;
      gyro_gain   <= GYRO_GAIN_RST;
      mag_gain    <= MAG_GAIN_RST;
      temp_gain   <= TEMP_GAIN_RST;
      temp_offset <= TEMP_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ACCEL_GAIN:  accel_gain  <= cfg_wdata;
        REG_GYRO_GAIN:   gyro_gain   <= cfg_wdata;
        REG_MAG_GAIN:    mag_gain    <= cfg_wdata;
        REG_TEMP_GAIN:   temp_gain   <= cfg_wdata;
        REG_TEMP_OFFSET: temp_offset <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Handshake: the product stage drains into the result register when it is free.
  assign s1_go     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_go;
  assign accept    = s_tvalid && s_tready;
  assign pos_cur   = (s_tuser || byte_position >= LAST_POS + POS_W'(1)) ? '0 : byte_position;
  assign final_acc = accept && (pos_cur == LAST_POS);

  // Byte count; a start flag forces the current word to position zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= (pos_cur == LAST_POS) ? '0 : pos_cur + POS_W'(1);
    end
  end

  // Frame store; bytes past the magnetometer field are not kept.
  always_ff @(posedge clk) begin
    if (accept && pos_cur < POS_W'(FIELD_BYTES)) begin
      frame_bytes[pos_cur] <= s_tdata;
    end
  end

  // Field extraction: big-endian pairs except the little-endian magnetometer.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_raw[i]    = {frame_bytes[MAG_BASE + 2*i + 1], frame_bytes[MAG_BASE + 2*i]};
      counts[i]     = $signed({frame_bytes[ACCEL_BASE + 2*i], frame_bytes[ACCEL_BASE + 2*i + 1]});
      counts[3 + i] = $signed({frame_bytes[GYRO_BASE + 2*i], frame_bytes[GYRO_BASE + 2*i + 1]});
      counts[6 + i] = $signed(mag_raw[i]);
      gains[i]      = accel_gain;
      gains[3 + i]  = gyro_gain;
      gains[6 + i]  = mag_gain;
      offsets[i]     = '0;
      offsets[3 + i] = '0;
      offsets[6 + i] = '0;
    end
    counts[9]  = $signed({frame_bytes[TEMP_BASE], frame_bytes[TEMP_BASE + 1]});
    gains[9]   = temp_gain;
    offsets[9] = temp_offset;
  end

  // A magnetometer sample is new on the first frame or when any axis moved.
  assign is_new = first_frame || (mag_raw[0] != previous_mag[0]) ||
                  (mag_raw[1] != previous_mag[1]) || (mag_raw[2] != previous_mag[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        previous_mag[i] <= '0;
      end
    end else if (final_acc && is_new) begin
      first_frame <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        previous_mag[i] <= mag_raw[i];
      end
    end
  end

  // Pipeline valids and the status flag riding beside the products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (final_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (final_acc) begin
      s1_mag_valid <= frame_bytes[STATUS_BYTE][0] || is_new;
    end
    if (s1_go) begin
      m_tuser <= s1_mag_valid;
    end
  end

  assign ctrl.prod_load = final_acc;
  assign ctrl.out_load  = s1_go;

  // One scaling lane per output field.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ifus_scale u_scale (
      .clk    (clk),
      .ctrl   (ctrl),
      .count  (counts[g]),
      .gain   (gains[g]),
      .offset (offsets[g]),
      .result (results[g])
    );
    assign m_tdata[g*Q_W +: Q_W] = results[g];
  end

endmodule

### sv/ifus_scale.sv
`timescale 1ns / 1ps

module ifus_scale import ifus_pkg::*; (
  input  logic                     clk,
  input  pipe_ctrl_t               ctrl,
  input  logic signed [COUNT_W-1:0] count,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [Q_W-1:0]    offset,
  output logic signed [Q_W-1:0]    result
);

  logic signed [PROD_W-1:0] mul;
  logic signed [PROD_W-1:0] prod;
  logic signed [SHR_W-1:0]  shifted;
  logic signed [Q_W-1:0]    scaled;
  logic signed [SHR_W-1:0]  sum;

  // The gain is unsigned, so it enters the signed multiply with a zero on top.
  assign mul = count * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod <= mul;
    end
  end

  // Dropping the low bits of a signed value rounds toward minus infinity.
  assign shifted = $signed(prod[PROD_W-1:FRAC_SHIFT]);
  assign scaled  = sat_q(shifted);
  assign sum     = SHR_W'(scaled) + SHR_W'(offset);

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      result <= sat_q(sum);
    end
  end

endmodule

### dv/imu_frame_checker.sv
`timescale 1ns / 1ps

// Follows the byte stream and the register port, predicts every scaled frame
// from the bytes taken in, and compares each delivered word with the oldest
// prediction still outstanding.
module imu_frame_checker import ifus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tuser,   // [0] frame_start
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_W-1:0]      m_tdata,   // accel x/y/z, gyro x/y/z, mag x/y/z,
                                           // temperature, 32 bits each from bit 0
  input  logic                  m_tuser,   // [0] mag_valid
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [GAIN_W-1:0]     cfg_wdata,
  output int                    mismatch_count,
  output int                    frames_due_count
);

  typedef struct packed {
    logic [LANES-1:0][Q_W-1:0] lane;
    logic                      mag_valid;
  } imu_frame_t;

  string lane_name [LANES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
                               "gyro_z", "mag_x", "mag_y", "mag_z", "temperature"};

  // Shadow copy of the registers and of the unpacking state.
  logic [GAIN_W-1:0]     accel_gain;
  logic [GAIN_W-1:0]     gyro_gain;
  logic [GAIN_W-1:0]     mag_gain;
  logic [GAIN_W-1:0]     temp_gain;
  logic signed [Q_W-1:0] temp_offset;
  int                    byte_pos;
  logic [7:0]            burst [FRAME_BYTES];
  logic [COUNT_W-1:0]    stored_mag [3];
  logic                  first_frame;
  imu_frame_t            frames_due [$];

  // Clamp to the signed Q16.16 range.
  function automatic logic [Q_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[Q_W-1:0];
  endfunction

  // Signed count times unsigned Q8.24 gain, shifted down to Q16.16 with floor.
  function automatic longint scale_count(input logic [COUNT_W-1:0] count,
                                         input logic [GAIN_W-1:0] gain);
    longint product;
    product = longint'($signed(count)) * longint'(gain);
    return product >>> FRAC_SHIFT;
  endfunction

  function automatic logic [COUNT_W-1:0] be_count(input int at);
    return {burst[at], burst[at + 1]};
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    imu_frame_t         want;
    logic [COUNT_W-1:0] mag_now [3];
    logic               fresh;
    if (rst) begin
      accel_gain  = ACCEL_GAIN_RST;
      gyro_gain   = GYRO_GAIN_RST;
      mag_gain    = MAG_GAIN_RST;
      temp_gain   = TEMP_GAIN_RST;
      temp_offset = TEMP_OFFSET_RST;
      byte_pos    = 0;
      stored_mag  = '{default: '0};
      first_frame = 1'b1;
      frames_due.delete();
    end else begin
      // A delivered frame is checked before this edge's byte can add a newer one.
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          report_error("frame delivered with none outstanding");
        end else begin
          want = frames_due.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (m_tdata[i*Q_W +: Q_W] !== want.lane[i]) begin
              report_error($sformatf("%s expected %h got %h", lane_name[i],
                                     want.lane[i], m_tdata[i*Q_W +: Q_W]));
            end
          end
          if (m_tuser !== want.mag_valid) begin
            report_error($sformatf("mag_valid expected %b got %b", want.mag_valid, m_tuser));
          end
        end
      end

      // Register writes.
      if (cfg_we) begin
        case (cfg_addr)
          REG_ACCEL_GAIN:  accel_gain  = cfg_wdata;
          REG_GYRO_GAIN:   gyro_gain   = cfg_wdata;
          REG_MAG_GAIN:    mag_gain    = cfg_wdata;
          REG_TEMP_GAIN:   temp_gain   = cfg_wdata;
          REG_TEMP_OFFSET: temp_offset = cfg_wdata;
          default: ;
        endcase
      end

      // Store the byte; the last byte of a burst produces a frame.
      if (s_tvalid && s_tready) begin
        if (s_tuser) byte_pos = 0;
        burst[byte_pos] = s_tdata;
        if (byte_pos != FRAME_BYTES - 1) begin
          byte_pos++;
        end else begin
          byte_pos = 0;
          for (int i = 0; i < 3; i++) begin
            want.lane[i]     = clamp_q16(scale_count(be_count(ACCEL_BASE + 2*i), accel_gain));
            want.lane[3 + i] = clamp_q16(scale_count(be_count(GYRO_BASE + 2*i), gyro_gain));
            mag_now[i]       = {burst[MAG_BASE + 2*i + 1], burst[MAG_BASE + 2*i]};
            want.lane[6 + i] = clamp_q16(scale_count(mag_now[i], mag_gain));
          end
          // The offset is added to the already clamped value and clamped again.
          want.lane[9] = clamp_q16(
              longint'($signed(clamp_q16(scale_count(be_count(TEMP_BASE), temp_gain))))
              + longint'(temp_offset));
          fresh = first_frame || mag_now[0] != stored_mag[0] ||
                  mag_now[1] != stored_mag[1] || mag_now[2] != stored_mag[2];
          // Only a new sample replaces the stored one; the ready bit alone does not.
          if (fresh) begin
            stored_mag  = mag_now;
            first_frame = 1'b0;
          end
          want.mag_valid = burst[STATUS_BYTE][0] || fresh;
          frames_due.push_back(want);
        end
      end
    end
    frames_due_count = frames_due.size();
  end

endmodule

### dv/tb_imu_frame_unpack_scale_top.sv
`timescale 1ns / 1ps

module tb_imu_frame_unpack_scale_top;
  import ifus_pkg::*;

  localparam int STUCK_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 4;
  localparam int DRAIN_TICKS  = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [7:0]            s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [GAIN_W-1:0]     cfg_wdata = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;

  int         mismatch_count;
  int         frames_due_count;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         stuck_cycles = 0;
  logic [7:0] burst_buf [FRAME_BYTES];
  logic [7:0] mag_buf [6];

  imu_frame_unpack_scale_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  imu_frame_checker u_frame_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .frames_due_count (frames_due_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random with the current phase's rate.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends the run when nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offers one byte after a random idle stretch and returns on the falling
  // edge after it was taken.
  task automatic push_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_burst(input logic start);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      push_byte(burst_buf[i], (i == 0) ? start : 1'b0);
    end
  endtask

  // Same count in every big-endian lane, one count in every magnetometer axis.
  task automatic fill_burst(input logic [15:0] imu_cnt, input logic [15:0] mag_cnt,
                            input logic [7:0] status);
    for (int k = 0; k < 7; k++) begin
      burst_buf[2*k]     = imu_cnt[15:8];
      burst_buf[2*k + 1] = imu_cnt[7:0];
    end
    burst_buf[STATUS_BYTE] = status;
    for (int k = 0; k < 3; k++) begin
      burst_buf[MAG_BASE + 2*k]     = mag_cnt[7:0];
      burst_buf[MAG_BASE + 2*k + 1] = mag_cnt[15:8];
    end
    burst_buf[21] = 8'($urandom);
    burst_buf[22] = 8'($urandom);
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Random burst; the magnetometer sample is often repeated so that unchanged
  // samples are common.
  task automatic random_burst();
    logic [15:0] c;
    for (int k = 0; k < 7; k++) begin
      c = pick_count();
      burst_buf[2*k]     = c[15:8];
      burst_buf[2*k + 1] = c[7:0];
    end
    burst_buf[STATUS_BYTE] = 8'($urandom);
    if ($urandom_range(2) == 0) begin
      for (int k = 0; k < 3; k++) begin
        c = pick_count();
        mag_buf[2*k]     = c[7:0];
        mag_buf[2*k + 1] = c[15:8];
      end
    end
    for (int k = 0; k < 6; k++) burst_buf[MAG_BASE + k] = mag_buf[k];
    burst_buf[21] = 8'($urandom);
    burst_buf[22] = 8'($urandom);
  endtask

  // Holds the input back until every predicted frame has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (frames_due_count != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] accel, input logic [31:0] gyro,
                              input logic [31:0] mag, input logic [31:0] temp,
                              input logic [31:0] offset);
    logic [CFG_ADDR_W-1:0] addr [5];
    logic [31:0]           value [5];
    addr  = '{REG_ACCEL_GAIN, REG_GYRO_GAIN, REG_MAG_GAIN, REG_TEMP_GAIN, REG_TEMP_OFFSET};
    value = '{accel, gyro, mag, temp, offset};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addr[i];
      cfg_wdata <= value[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k;
    for (int i = 0; i < 6; i++) mag_buf[i] = 8'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First frame after reset reports the magnetometer even though the sample
    // equals the cleared stored one.
    fill_burst(16'h1234, 16'h0000, 8'h00);
    send_burst(1'b1);
    // Unchanged sample with only the upper status bits set: not reported; the
    // negative counts check the floor rounding.
    fill_burst(16'hFFFF, 16'h0000, 8'hFE);
    send_burst(1'b1);
    // Ready bit alone reports, with no start flag on a clean boundary.
    fill_burst(16'h7FFF, 16'h0000, 8'h01);
    send_burst(1'b0);
    // Changed sample.
    fill_burst(16'h8000, 16'h8000, 8'h00);
    send_burst(1'b1);
    // A burst cut short by a new start flag.
    for (int i = 0; i < 7; i++) push_byte(8'($urandom), i == 0);
    fill_burst(16'h0001, 16'h7FFF, 8'h00);
    send_burst(1'b1);

    // Largest gains and offset: saturation at both ends.
    wait_drained();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    fill_burst(16'h7FFF, 16'h7FFF, 8'h00);
    send_burst(1'b1);
    fill_burst(16'h8000, 16'h8000, 8'h01);
    send_burst(1'b1);
    fill_burst(16'h0000, 16'h0000, 8'h00);
    send_burst(1'b1);

    // Zero gains, the smallest nonzero gyro gain, the largest temperature gain, most negative offset.
    wait_drained();
    program_regs(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    fill_burst(16'h8000, 16'h5A5A, 8'h00);
    send_burst(1'b1);
    fill_burst(16'h7FFF, 16'hA5A5, 8'h00);
    send_burst(1'b1);

    // Random phases, each with its own register setting and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      program_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      for (int n = 0; n < 13; n++) begin
        if ($urandom_range(9) < 8) begin
          random_burst();
          send_burst($urandom_range(4) != 0);
        end else begin
          // Broken burst: 1 to 22 random bytes with stray start flags.
          k = $urandom_range(1, FRAME_BYTES - 1);
          for (int j = 0; j < k; j++) push_byte(8'($urandom), $urandom_range(3) == 0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_TICKS) @(negedge clk);
    if (mismatch_count == 0 && frames_due_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
